/* src/assert_macros.svh */
// Assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* src/erp_pkg.sv */
// ---------------------------------------------------------------------------
// erp_pkg
// Shared constants, types and functions of the Euler point rotation core.
// ---------------------------------------------------------------------------
package erp_pkg;
   localparam int CordicStepsDef   = 16;
   localparam int CoordFracBitsDef = 16;
   localparam int AtanEntries      = 24;
   localparam int AngW             = 17;
   localparam int TrigW            = 19;
   localparam int ZW               = 27;
   localparam int CorW             = 20;
   localparam int CoordW           = 32;
   localparam int AngleFull        = 46080;
   localparam int AngleHalf        = 23040;
   localparam int AngleQuarter     = 11520;
   localparam int CordicGain       = 39797;
   localparam int TrigOne          = 65536;
   localparam int ReqBytes         = 19;
   localparam int RspBytes         = 12;

   // one CORDIC lane in flight
   typedef struct packed {
      logic signed [CorW-1:0] x;
      logic signed [CorW-1:0] y;
      logic signed [ZW-1:0]   z;
      logic                   neg;
   } cordic_lane_type;

   // payload that rides alongside the CORDIC cells
   typedef struct packed {
      logic signed [CoordW-1:0] px;
      logic signed [CoordW-1:0] py;
      logic signed [CoordW-1:0] pz;
   } point_type;

   function automatic logic signed [ZW-1:0] atan_lut(input int idx);
      logic signed [ZW-1:0] t;
      unique case (idx)
         0: t = 27'sd2949120;  1: t = 27'sd1740967;  2: t = 27'sd919879;
         3: t = 27'sd466945;   4: t = 27'sd234379;   5: t = 27'sd117304;
         6: t = 27'sd58666;    7: t = 27'sd29335;    8: t = 27'sd14668;
         9: t = 27'sd7334;     10: t = 27'sd3667;    11: t = 27'sd1833;
         12: t = 27'sd917;     13: t = 27'sd458;     14: t = 27'sd229;
         15: t = 27'sd115;     16: t = 27'sd57;      17: t = 27'sd29;
         18: t = 27'sd14;      19: t = 27'sd7;       20: t = 27'sd4;
         21: t = 27'sd2;       22: t = 27'sd1;       default: t = '0;
      endcase
      return t;
   endfunction

   // angle reduction into [-90, 90] degrees, z in degrees Q16
   function automatic cordic_lane_type cordic_seed(input logic signed [AngW-1:0] ang);
      cordic_lane_type l;
      logic signed [AngW+1:0] r;
      r = {{2{ang[AngW-1]}}, ang};
      if (r >= 19'sd46080) r = r - 19'sd46080;
      else if (r <= -19'sd46080) r = r + 19'sd46080;
      if (r < 0) r = r + 19'sd46080;
      if (r > 19'sd23040) r = r - 19'sd46080;
      l.neg = 1'b0;
      if (r > 19'sd11520) begin
         r = r - 19'sd23040;
         l.neg = 1'b1;
      end else if (r < -19'sd11520) begin
         r = r + 19'sd23040;
         l.neg = 1'b1;
      end
      l.x = CorW'(CordicGain);
      l.y = '0;
      l.z = ZW'(r) <<< 9;
      return l;
   endfunction

   // rounded Q16 product
   function automatic logic signed [TrigW-1:0] qmul(input logic signed [TrigW-1:0] a,
                                                  input logic signed [TrigW-1:0] b);
      logic signed [2*TrigW-1:0] p;
      p = a * b + (2*TrigW)'(32768);
      return TrigW'(p >>> 16);
   endfunction

   function automatic logic signed [TrigW-1:0] trig_clamp(input logic signed [CorW-1:0] v,
                                                        input logic neg);
      logic signed [CorW-1:0] c;
      c = v;
      if (v > CorW'(TrigOne)) c = CorW'(TrigOne);
      else if (v < -CorW'(TrigOne)) c = -CorW'(TrigOne);
      if (neg) c = -c;
      return TrigW'(c);
   endfunction
endpackage

/* src/erp_cordic_cell.sv */
// ---------------------------------------------------------------------------
// erp_cordic_cell
// One CORDIC micro-rotation on three lanes, registered, with fixed shift.
// ---------------------------------------------------------------------------
module erp_cordic_cell import erp_pkg::*; #(
   parameter int Step = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  vld_in,
   input  cordic_lane_type [2:0] lane_in,
   input  point_type             pt_in,
   output logic                  vld_out,
   output cordic_lane_type [2:0] lane_out,
   output point_type             pt_out
);
   localparam logic signed [ZW-1:0] Atan = atan_lut(Step);

   logic                  vld_ff;
   cordic_lane_type [2:0] lane_ff, lane_in_c;
   point_type             pt_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lane_in_c[k].neg = lane_in[k].neg;
         if (!lane_in[k].z[ZW-1]) begin
            lane_in_c[k].x = lane_in[k].x - (lane_in[k].y >>> Step);
            lane_in_c[k].y = lane_in[k].y + (lane_in[k].x >>> Step);
            lane_in_c[k].z = lane_in[k].z - Atan;
         end else begin
            lane_in_c[k].x = lane_in[k].x + (lane_in[k].y >>> Step);
            lane_in_c[k].y = lane_in[k].y - (lane_in[k].x >>> Step);
            lane_in_c[k].z = lane_in[k].z + Atan;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
      if (en) begin
         lane_ff <= lane_in_c;
         pt_ff   <= pt_in;
      end
   end

   assign vld_out  = vld_ff;
   assign lane_out = lane_ff;
   assign pt_out   = pt_ff;
endmodule

/* src/erp_matrix.sv */
// ---------------------------------------------------------------------------
// erp_matrix
// Builds the yaw-pitch-roll matrix and applies it to the point, saturating.
// ---------------------------------------------------------------------------
module erp_matrix import erp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     vld_in,
   input  cordic_lane_type [2:0]    lane_in,
   input  point_type                pt_in,
   output logic                     vld_out,
   output logic [3*CoordW-1:0]      res_out
);
   localparam int PW = TrigW + CoordW;
   localparam int AW = PW + 2;

   logic [4:0] vld_ff;
   logic signed [TrigW-1:0] sa_ff, ca_ff, sb_ff, cb_ff, sc_ff, cc_ff;
   point_type pt1_ff, pt2_ff, pt3_ff;
   logic signed [TrigW-1:0] casb_ff, sasb_ff, sacc_ff, sasc_ff, cacc_ff, casc_ff;
   logic signed [TrigW-1:0] cacb_ff, sacb_ff, cbsc_ff, cbcc_ff, nsb_ff, sc2_ff, cc2_ff;
   logic signed [TrigW-1:0] m_ff [9];
   logic signed [PW-1:0] p_ff [9];
   logic signed [CoordW-1:0] r_ff [3];
   logic signed [AW-1:0] acc [3];
   logic signed [AW-17:0] sh [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         acc[k] = AW'(p_ff[3*k]) + AW'(p_ff[3*k+1]) + AW'(p_ff[3*k+2]) + AW'(32768);
         sh[k]  = (AW-16)'(acc[k] >>> 16);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], vld_in};
      end
      if (en) begin
         ca_ff <= trig_clamp(lane_in[0].x, lane_in[0].neg);
         sa_ff <= trig_clamp(lane_in[0].y, lane_in[0].neg);
         cb_ff <= trig_clamp(lane_in[1].x, lane_in[1].neg);
         sb_ff <= trig_clamp(lane_in[1].y, lane_in[1].neg);
         cc_ff <= trig_clamp(lane_in[2].x, lane_in[2].neg);
         sc_ff <= trig_clamp(lane_in[2].y, lane_in[2].neg);
         pt1_ff <= pt_in;
         casb_ff <= qmul(ca_ff, sb_ff);
         sasb_ff <= qmul(sa_ff, sb_ff);
         sacc_ff <= qmul(sa_ff, cc_ff);
         sasc_ff <= qmul(sa_ff, sc_ff);
         cacc_ff <= qmul(ca_ff, cc_ff);
         casc_ff <= qmul(ca_ff, sc_ff);
         cacb_ff <= qmul(ca_ff, cb_ff);
         sacb_ff <= qmul(sa_ff, cb_ff);
         cbsc_ff <= qmul(cb_ff, sc_ff);
         cbcc_ff <= qmul(cb_ff, cc_ff);
         nsb_ff  <= -sb_ff;
         sc2_ff  <= sc_ff;
         cc2_ff  <= cc_ff;
         pt2_ff  <= pt1_ff;
         m_ff[0] <= cacb_ff;
         m_ff[1] <= qmul(casb_ff, sc2_ff) - sacc_ff;
         m_ff[2] <= qmul(casb_ff, cc2_ff) + sasc_ff;
         m_ff[3] <= sacb_ff;
         m_ff[4] <= qmul(sasb_ff, sc2_ff) + cacc_ff;
         m_ff[5] <= qmul(sasb_ff, cc2_ff) - casc_ff;
         m_ff[6] <= nsb_ff;
         m_ff[7] <= cbsc_ff;
         m_ff[8] <= cbcc_ff;
         pt3_ff  <= pt2_ff;
         for (int k = 0; k < 3; k++) begin
            p_ff[3*k]   <= m_ff[3*k]   * pt3_ff.px;
            p_ff[3*k+1] <= m_ff[3*k+1] * pt3_ff.py;
            p_ff[3*k+2] <= m_ff[3*k+2] * pt3_ff.pz;
         end
         for (int k = 0; k < 3; k++) begin
            if (sh[k] > (AW-16)'(32'sh7fffffff)) r_ff[k] <= 32'sh7fffffff;
            else if (sh[k] < -(AW-16)'(33'sh80000000)) r_ff[k] <= 32'sh80000000;
            else r_ff[k] <= CoordW'(sh[k]);
         end
      end
   end

   assign vld_out = vld_ff[4];
   assign res_out = {r_ff[2], r_ff[1], r_ff[0]};
endmodule

/* src/euler_rotate_point_core.sv */
// ---------------------------------------------------------------------------
// euler_rotate_point_core
// Rotates one Q16.16 point per item by yaw, pitch and roll (Z, Y, X).
// ---------------------------------------------------------------------------
// Input channel req_*: tdata carries point_x, point_y, point_z, pitch_angle,
// yaw_angle, roll_angle from bit 0 up, padded to 19 bytes. Result channel
// rsp_*: tdata carries rot_x, rot_y, rot_z, 12 bytes. One result per item.
// From acceptance to rsp_tvalid an item passes one register per CORDIC cell
// (three angles share each cell) and five matrix stages. Throughput is
// one item per cycle unless the receiver stalls. The pipeline advances whenever
// the output register is empty or being read, so a stalled receiver holds
// the whole chain and req_tready drops until the result is taken. Reset
// empties the pipeline; no item is in flight afterwards. The
// COORD_FRAC_BITS parameter only records the coordinate format.
// ---------------------------------------------------------------------------
module euler_rotate_point_core import erp_pkg::*; #(
   parameter int CORDIC_STEPS    = CordicStepsDef,
   parameter int COORD_FRAC_BITS = CoordFracBitsDef
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // point_x, point_y, point_z, pitch_angle, yaw_angle, roll_angle, zero pad
   input  logic [8*ReqBytes-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rot_x, rot_y, rot_z
   output logic [8*RspBytes-1:0] rsp_tdata
);
   localparam int FracCheck = COORD_FRAC_BITS;

   logic en;
   logic                  vld [CORDIC_STEPS+1];
   cordic_lane_type [2:0] lane [CORDIC_STEPS+1];
   point_type             pt [CORDIC_STEPS+1];
   logic                  mvld;
   logic [3*CoordW-1:0]   mres;

   assign en         = !rsp_tvalid || rsp_tready || (FracCheck < 0);
   assign req_tready = en;

   assign vld[0]     = req_tvalid;
   assign pt[0].px   = req_tdata[31:0];
   assign pt[0].py   = req_tdata[63:32];
   assign pt[0].pz   = req_tdata[95:64];
   assign lane[0][0] = cordic_seed(req_tdata[129:113]);
   assign lane[0][1] = cordic_seed(req_tdata[112:96]);
   assign lane[0][2] = cordic_seed(req_tdata[146:130]);

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      erp_cordic_cell #(.Step(i)) u_cell (
         .clock, .reset, .en,
         .vld_in(vld[i]), .lane_in(lane[i]), .pt_in(pt[i]),
         .vld_out(vld[i+1]), .lane_out(lane[i+1]), .pt_out(pt[i+1])
      );
   end

   erp_matrix u_matrix (
      .clock, .reset, .en,
      .vld_in(vld[CORDIC_STEPS]), .lane_in(lane[CORDIC_STEPS]),
      .pt_in(pt[CORDIC_STEPS]), .vld_out(mvld), .res_out(mres)
   );

   assign rsp_tvalid = mvld;
   assign rsp_tdata  = mres;
endmodule

/* src/erp_checker.sv */
// ---------------------------------------------------------------------------
// erp_checker
// Port-level checks of the Euler point rotation core.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module erp_checker import erp_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [8*RspBytes-1:0] rsp_tdata
)
;
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_IMP(a_ready_free, clock, reset, !rsp_tvalid || rsp_tready, req_tready)
   `ASSERT_IMP(a_stall_blocks, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)
endmodule

bind euler_rotate_point_core erp_checker u_erp_checker (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);

/* test/euler_rotate_point_core_tb.sv */
// ---------------------------------------------------------------------------
// euler_rotate_point_core_tb
// Streams points with yaw/pitch/roll angles through the rotation core and
// checks every rotated point against a cycle-free fixed-point predictor.
// ---------------------------------------------------------------------------
module euler_rotate_point_core_tb;
   import erp_pkg::*;

   typedef struct packed {
      logic [4:0]         pad;
      logic signed [16:0] roll;
      logic signed [16:0] yaw;
      logic signed [16:0] pitch;
      logic signed [31:0] pz;
      logic signed [31:0] py;
      logic signed [31:0] px;
   } point_item_t;

   typedef struct packed {
      logic signed [31:0] rz;
      logic signed [31:0] ry;
      logic signed [31:0] rx;
   } rot_item_t;

   localparam int Steps = CordicStepsDef;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [8*ReqBytes-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [8*RspBytes-1:0] rsp_tdata;

   point_item_t pending_points[$];
   rot_item_t   expected_rots[$];
   int          fail_count;
   bit          stim_done;
   bit          calm;
   int          send_gap;
   int          recv_gap;
   int          hold_off;
   bit          hold_armed;

   euler_rotate_point_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   function automatic longint asr16(longint v);
      return v >>> 16;
   endfunction

   function automatic longint qm(longint a, longint b);
      return asr16(a * b + 32768);
   endfunction

   function automatic void trig_of(longint ang, output longint s, output longint c);
      longint atan_q16[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
      longint r, x, y, z, dx, dy;
      bit flip;
      r = ang % AngleFull;
      flip = 0;
      if (r < 0) r += AngleFull;
      if (r > AngleHalf) r -= AngleFull;
      if (r > AngleQuarter) begin
         r -= AngleHalf;
         flip = 1;
      end else if (r < -AngleQuarter) begin
         r += AngleHalf;
         flip = 1;
      end
      x = CordicGain;
      y = 0;
      z = r * 512;
      for (int i = 0; i < Steps && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_q16[i];
         end else begin
            x += dx; y -= dy; z += atan_q16[i];
         end
      end
      if (x > TrigOne) x = TrigOne;
      if (x < -TrigOne) x = -TrigOne;
      if (y > TrigOne) y = TrigOne;
      if (y < -TrigOne) y = -TrigOne;
      if (flip) begin
         x = -x; y = -y;
      end
      c = x;
      s = y;
   endfunction

   function automatic logic [31:0] sat_row(longint e0, longint e1, longint e2,
                                           longint px, longint py, longint pz);
      longint v;
      v = asr16(e0 * px + e1 * py + e2 * pz + 32768);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic rot_item_t rotate_point(point_item_t p);
      rot_item_t r;
      longint sa, ca, sb, cb, sc, cc, px, py, pz;
      px = p.px; py = p.py; pz = p.pz;
      trig_of(p.yaw, sa, ca);
      trig_of(p.pitch, sb, cb);
      trig_of(p.roll, sc, cc);
      r.rx = sat_row(qm(ca, cb), qm(qm(ca, sb), sc) - qm(sa, cc),
                     qm(qm(ca, sb), cc) + qm(sa, sc), px, py, pz);
      r.ry = sat_row(qm(sa, cb), qm(qm(sa, sb), sc) + qm(ca, cc),
                     qm(qm(sa, sb), cc) - qm(ca, sc), px, py, pz);
      r.rz = sat_row(-sb, qm(cb, sc), qm(cb, cc), px, py, pz);
      return r;
   endfunction

   function automatic logic signed [16:0] rand_angle();
      case ($urandom_range(0, 5))
         0: return 17'($signed($urandom_range(0, 92160)) - 46080);
         1: return 17'($signed($urandom_range(0, 8)) * 5760 - 23040);
         2: return 17'($urandom);
         default: return 17'($signed($urandom_range(0, 1440)) - 720);
      endcase
   endfunction

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
         default: return 32'($signed($urandom_range(0, 400000)) - 200000) <<< 8;
      endcase
   endfunction

   function automatic void push_point(logic signed [31:0] x, logic signed [31:0] y,
                                      logic signed [31:0] z, logic signed [16:0] pt,
                                      logic signed [16:0] yw, logic signed [16:0] rl);
      point_item_t p;
      p = '0;
      p.px = x; p.py = y; p.pz = z;
      p.pitch = pt; p.yaw = yw; p.roll = rl;
      pending_points.push_back(p);
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      logic signed [16:0] angs[7] = '{0, 46080, -46080, 11520, -11520, 23040, 65535};
      // directed: zero, full turns, quarter and half turns, extremes, overflow
      push_point(32'h00010000, 32'h00020000, 32'h00030000, 0, 0, 0);
      for (int i = 0; i < 7; i++)
         push_point(32'h00010000, 32'hfffe0000, 32'h00008000, angs[i], angs[(i+2)%7],
                    angs[(i+4)%7]);
      push_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 5760, 5760, 5760);
      push_point(32'h80000000, 32'h80000000, 32'h80000000, -5760, 5760, -5760);
      push_point(32'h7fffffff, 32'h80000000, 32'h00000000, 17'sh10000, 17'sh0ffff, 1);
      push_point(32'hffffffff, 32'h00000001, 32'h55555555, 11519, -11521, 23041);
      push_point(32'haaaaaaaa, 32'h12345678, 32'hedcba987, 17'sh15555, 17'sh0aaaa, 6);
      for (int i = 0; i < 400; i++)
         push_point(rand_coord(), rand_coord(), rand_coord(), rand_angle(), rand_angle(),
                    rand_angle());
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata  <= '0;
         send_gap   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            req_tvalid <= 0;
            send_gap   <= send_gap - 1;
         end else if (pending_points.size() > 0) begin
            point_item_t p;
            p = pending_points.pop_front();
            expected_rots.push_back(rotate_point(p));
            req_tvalid <= 1;
            req_tdata  <= p;
            if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 5);
         end else begin
            req_tvalid <= 0;
            stim_done  <= 1;
         end
      end
   end

   // monitor and receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         recv_gap   <= 0;
         hold_off   <= 0;
         hold_armed <= 1;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rot_item_t got, want;
            got = rsp_tdata;
            if (expected_rots.size() == 0) begin
               $error("unexpected rotated point %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_rots.pop_front();
               if (got.rx !== want.rx) begin
                  $error("rot_x expected %0d got %0d", want.rx, got.rx);
                  fail_count++;
               end
               if (got.ry !== want.ry) begin
                  $error("rot_y expected %0d got %0d", want.ry, got.ry);
                  fail_count++;
               end
               if (got.rz !== want.rz) begin
                  $error("rot_z expected %0d got %0d", want.rz, got.rz);
                  fail_count++;
               end
            end
         end
         if (hold_armed && pending_points.size() < 300) begin
            hold_armed <= 0;
            hold_off   <= 80;
            rsp_tready <= 0;
         end else if (hold_off > 0) begin
            hold_off   <= hold_off - 1;
            rsp_tready <= 0;
         end else if (recv_gap > 0) begin
            recv_gap   <= recv_gap - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
            if (!calm && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 5);
         end
      end
   end

   initial begin
      fail_count = 0;
      stim_done  = 0;
      calm       = 0;
      reset      = 1;
      req_tvalid = 0;
      req_tdata  = '0;
      rsp_tready = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      wait (pending_points.size() > 0 && pending_points.size() < 60);
      calm = 1;
      wait (stim_done && expected_rots.size() == 0);
      repeat (Steps + 20) @(posedge clock);
      if (fail_count == 0 && expected_rots.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #500000;
      $display("Verification failed");
      $finish;
   end
endmodule

/* euler_rotate_point_core.f */
+incdir+src
src/erp_pkg.sv
src/erp_cordic_cell.sv
src/erp_matrix.sv
src/euler_rotate_point_core.sv
src/erp_checker.sv
test/euler_rotate_point_core_tb.sv
